// File: hdl/stroke_moving_average_smoother_core_macros.svh
`ifndef STROKE_MOVING_AVERAGE_SMOOTHER_CORE_MACROS_SVH
`define STROKE_MOVING_AVERAGE_SMOOTHER_CORE_MACROS_SVH

// Implication checked in the next cycle.
`define SMAS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

// Implication checked in the same cycle.
`define SMAS_ASSERT_SAME(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

`endif

// File: hdl/smas_pkg.sv
package smas_pkg;

	localparam int MAX_HALF_WINDOW = 8;
	localparam int COORD_BITS = 16;
	localparam int DEPTH = 2 * MAX_HALF_WINDOW + 1;
	localparam int CFG_BITS = 4;
	localparam int HALF_BITS = $clog2(MAX_HALF_WINDOW + 1);
	localparam int IDX_BITS = $clog2(DEPTH);
	localparam int CNT_BITS = $clog2(DEPTH + 1);
	localparam int WEIGHT_BITS = $clog2(DEPTH + 1);
	localparam int SUM_BITS = COORD_BITS + WEIGHT_BITS;
	localparam int DIV_CNT_BITS = $clog2(SUM_BITS);

	localparam logic [CFG_BITS-1:0] HALF_RESET = CFG_BITS'(1);

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x_coord;
		logic signed [COORD_BITS-1:0] y_coord;
		logic                         stroke_end;
		logic                         pen_is_down;
	} point_in_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] smooth_x;
		logic signed [COORD_BITS-1:0] smooth_y;
		logic                         last_of_stroke;
		logic                         pen_down_out;
	} point_out_t;

	// Broadcast to every cell of the window chain.
	typedef struct packed {
		logic                 shift;
		logic [HALF_BITS-1:0] q;
		logic [HALF_BITS-1:0] k;
		logic [IDX_BITS-1:0]  j;
	} smas_ctrl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SUM,
		ST_DIV,
		ST_PUT
	} smas_state_t;

	function automatic logic [HALF_BITS-1:0] eff_half(input logic [CFG_BITS-1:0] raw);
		if (int'(raw) > MAX_HALF_WINDOW) begin
			return HALF_BITS'(MAX_HALF_WINDOW);
		end
		return HALF_BITS'(raw);
	endfunction

endpackage

// File: hdl/smas_cell.sv
module smas_cell (
	input  logic                                   clk,
	input  logic [smas_pkg::IDX_BITS-1:0]          idx,
	input  smas_pkg::smas_ctrl_t                   ctrl,
	input  logic signed [smas_pkg::COORD_BITS-1:0] x_in,
	input  logic signed [smas_pkg::COORD_BITS-1:0] y_in,
	input  logic signed [smas_pkg::SUM_BITS-1:0]   psx_in,
	input  logic signed [smas_pkg::SUM_BITS-1:0]   psy_in,
	output logic signed [smas_pkg::COORD_BITS-1:0] x_out,
	output logic signed [smas_pkg::COORD_BITS-1:0] y_out,
	output logic signed [smas_pkg::SUM_BITS-1:0]   psx_out,
	output logic signed [smas_pkg::SUM_BITS-1:0]   psy_out
);

	logic signed [smas_pkg::COORD_BITS-1:0] x_q;
	logic signed [smas_pkg::COORD_BITS-1:0] y_q;
	logic signed [smas_pkg::SUM_BITS-1:0]   psx_q;
	logic signed [smas_pkg::SUM_BITS-1:0]   psy_q;
	logic [smas_pkg::IDX_BITS-1:0]          hi;
	logic                                   in_win;
	logic [smas_pkg::WEIGHT_BITS-1:0]       w_first;
	logic [smas_pkg::WEIGHT_BITS-1:0]       w_last;
	logic [smas_pkg::WEIGHT_BITS-1:0]       w;
	logic signed [smas_pkg::SUM_BITS-1:0]   w_s;
	logic signed [smas_pkg::SUM_BITS-1:0]   term_x;
	logic signed [smas_pkg::SUM_BITS-1:0]   term_y;

	// The window spans lags q-k .. q+k. Lags below zero fold onto the newest
	// point (cell 0) and lags beyond j fold onto the stroke's first point.
	assign hi      = smas_pkg::IDX_BITS'(ctrl.q) + smas_pkg::IDX_BITS'(ctrl.k);
	assign in_win  = (idx <= hi) && (idx <= ctrl.j);
	assign w_first = (idx == '0) ? smas_pkg::WEIGHT_BITS'(ctrl.k - ctrl.q) : '0;
	assign w_last  = (idx == ctrl.j && hi > ctrl.j) ?
		smas_pkg::WEIGHT_BITS'(hi - ctrl.j) : '0;
	assign w       = smas_pkg::WEIGHT_BITS'(in_win) + w_first + w_last;
	assign w_s     = $signed(smas_pkg::SUM_BITS'({1'b0, w}));

	// Entries with zero weight are kept out of the sum entirely, so stale
	// entries never disturb it.
	assign term_x = (w == '0) ? '0 : smas_pkg::SUM_BITS'(x_q) * w_s;
	assign term_y = (w == '0) ? '0 : smas_pkg::SUM_BITS'(y_q) * w_s;

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			x_q <= x_in;
			y_q <= y_in;
		end
		psx_q <= psx_in + term_x;
		psy_q <= psy_in + term_y;
	end

	assign x_out   = x_q;
	assign y_out   = y_q;
	assign psx_out = psx_q;
	assign psy_out = psy_q;

endmodule

// File: hdl/smas_div.sv
module smas_div (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic [smas_pkg::WEIGHT_BITS-1:0]       den,
	input  logic signed [smas_pkg::SUM_BITS-1:0]   num_x,
	input  logic signed [smas_pkg::SUM_BITS-1:0]   num_y,
	output logic                                   done,
	output logic signed [smas_pkg::COORD_BITS-1:0] quot_x,
	output logic signed [smas_pkg::COORD_BITS-1:0] quot_y
);

	logic                                  busy_q;
	logic                                  done_q;
	logic [smas_pkg::DIV_CNT_BITS-1:0]     cnt_q;
	logic [smas_pkg::WEIGHT_BITS-1:0]      den_q;
	logic                                  neg_x_q;
	logic                                  neg_y_q;
	logic [smas_pkg::SUM_BITS-1:0]         shx_q;
	logic [smas_pkg::SUM_BITS-1:0]         shy_q;
	logic [smas_pkg::WEIGHT_BITS-1:0]      remx_q;
	logic [smas_pkg::WEIGHT_BITS-1:0]      remy_q;
	logic [smas_pkg::SUM_BITS-1:0]         mag_x;
	logic [smas_pkg::SUM_BITS-1:0]         mag_y;
	logic [smas_pkg::WEIGHT_BITS:0]        trial_x;
	logic [smas_pkg::WEIGHT_BITS:0]        trial_y;
	logic                                  ge_x;
	logic                                  ge_y;
	logic [smas_pkg::WEIGHT_BITS-1:0]      remx_d;
	logic [smas_pkg::WEIGHT_BITS-1:0]      remy_d;
	logic [smas_pkg::SUM_BITS-1:0]         qx;
	logic [smas_pkg::SUM_BITS-1:0]         qy;
	logic                                  last_step;

	assign mag_x = num_x[smas_pkg::SUM_BITS-1] ?
		smas_pkg::SUM_BITS'(-num_x) : smas_pkg::SUM_BITS'(num_x);
	assign mag_y = num_y[smas_pkg::SUM_BITS-1] ?
		smas_pkg::SUM_BITS'(-num_y) : smas_pkg::SUM_BITS'(num_y);

	// Restoring division, one quotient bit per cycle on both coordinates.
	assign trial_x = {remx_q, shx_q[smas_pkg::SUM_BITS-1]};
	assign trial_y = {remy_q, shy_q[smas_pkg::SUM_BITS-1]};
	assign ge_x    = trial_x >= {1'b0, den_q};
	assign ge_y    = trial_y >= {1'b0, den_q};
	assign remx_d  = ge_x ? smas_pkg::WEIGHT_BITS'(trial_x - {1'b0, den_q}) :
		smas_pkg::WEIGHT_BITS'(trial_x);
	assign remy_d  = ge_y ? smas_pkg::WEIGHT_BITS'(trial_y - {1'b0, den_q}) :
		smas_pkg::WEIGHT_BITS'(trial_y);

	assign last_step = busy_q && (cnt_q == smas_pkg::DIV_CNT_BITS'(smas_pkg::SUM_BITS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= last_step;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + smas_pkg::DIV_CNT_BITS'(1);
				if (last_step) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q   <= den;
			neg_x_q <= num_x[smas_pkg::SUM_BITS-1];
			neg_y_q <= num_y[smas_pkg::SUM_BITS-1];
			shx_q   <= mag_x;
			shy_q   <= mag_y;
			remx_q  <= '0;
			remy_q  <= '0;
		end else if (busy_q) begin
			shx_q  <= {shx_q[smas_pkg::SUM_BITS-2:0], ge_x};
			shy_q  <= {shy_q[smas_pkg::SUM_BITS-2:0], ge_y};
			remx_q <= remx_d;
			remy_q <= remy_d;
		end
	end

	// Quotient magnitude is restored to the dividend's sign: truncation toward zero.
	assign qx     = neg_x_q ? -shx_q : shx_q;
	assign qy     = neg_y_q ? -shy_q : shy_q;
	assign quot_x = $signed(qx[smas_pkg::COORD_BITS-1:0]);
	assign quot_y = $signed(qy[smas_pkg::COORD_BITS-1:0]);
	assign done   = done_q;

endmodule

// File: hdl/stroke_moving_average_smoother_core.sv
// Stroke smoother: each output word is the mean of 2k+1 pen points centered
// on one point of the stroke, with the stroke's first and last points
// repeated past its ends. k comes from the half-window register (above 8
// counts as 8).
// Input channel (in_valid/in_stall/in_data) takes one pen point per word; a
// word is taken when in_valid is high and in_stall is low. Output channel
// (out_valid/out_stall/out_data) delivers smoothed points the same way.
// The configuration channel (cfg_valid/cfg_ready/cfg_data) writes the half
// window; cfg_ready is always high. It must be written only while idle; the block itself does not enforce this.
// A point that produces no result (the first k points of a stroke, unless it
// ends the stroke) leaves the input open. Each result passes through the
// weighted window sum down the 17-cell chain, then the bit-serial divider by
// 2k+1, then the hand-off. A point that ends a stroke flushes up to k+1 results
// one after another while the input stays stalled. Output lags the stroke by k points.
// The output word sits in a register: while the receiver stalls it holds
// steady, and the next input word is taken as soon as the last result of the
// previous one is loaded there. Reset empties the stroke, clears the output
// valid and sets the half window to 1.
module stroke_moving_average_smoother_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  smas_pkg::point_in_t                 in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output smas_pkg::point_out_t                out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [smas_pkg::CFG_BITS-1:0]       cfg_data
);

	smas_pkg::smas_state_t                  state_q;
	smas_pkg::smas_state_t                  state_d;
	logic [smas_pkg::CFG_BITS-1:0]          half_q;
	logic [smas_pkg::CNT_BITS-1:0]          pts_q;
	logic                                   pen_q;
	logic [smas_pkg::IDX_BITS-1:0]          j_q;
	logic [smas_pkg::HALF_BITS-1:0]         q_q;
	logic                                   end_q;
	logic [smas_pkg::CNT_BITS-1:0]          sum_cnt_q;
	logic                                   out_valid_q;
	smas_pkg::point_out_t                   out_q;

	logic [smas_pkg::HALF_BITS-1:0]         k;
	logic [smas_pkg::IDX_BITS-1:0]          k_ext;
	logic [smas_pkg::CNT_BITS-1:0]          pts_inc;
	logic [smas_pkg::IDX_BITS-1:0]          jn;
	logic                                   accept;
	logic                                   out_free;
	logic                                   div_start;
	logic                                   div_done;
	logic                                   load_out;
	logic                                   more;
	smas_pkg::smas_ctrl_t                   ctrl;
	logic signed [smas_pkg::COORD_BITS-1:0] quot_x;
	logic signed [smas_pkg::COORD_BITS-1:0] quot_y;

	logic signed [smas_pkg::COORD_BITS-1:0] x_st  [smas_pkg::DEPTH];
	logic signed [smas_pkg::COORD_BITS-1:0] y_st  [smas_pkg::DEPTH];
	logic signed [smas_pkg::SUM_BITS-1:0]   ps_x  [smas_pkg::DEPTH];
	logic signed [smas_pkg::SUM_BITS-1:0]   ps_y  [smas_pkg::DEPTH];

	assign k        = smas_pkg::eff_half(half_q);
	assign k_ext    = smas_pkg::IDX_BITS'(k);
	assign pts_inc  = (pts_q < smas_pkg::CNT_BITS'(smas_pkg::DEPTH)) ?
		pts_q + smas_pkg::CNT_BITS'(1) : pts_q;
	assign jn       = smas_pkg::IDX_BITS'(pts_inc - smas_pkg::CNT_BITS'(1));
	assign in_stall = (state_q != smas_pkg::ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign more     = end_q && (q_q != '0);

	assign ctrl.shift = accept;
	assign ctrl.q     = q_q;
	assign ctrl.k     = k;
	assign ctrl.j     = j_q;

	// Row of cells: cell i holds the point i places back from the newest and
	// adds its weighted share to the partial sum arriving from cell i-1.
	for (genvar i = 0; i < smas_pkg::DEPTH; i++) begin : g_cell
		logic signed [smas_pkg::COORD_BITS-1:0] xin;
		logic signed [smas_pkg::COORD_BITS-1:0] yin;
		logic signed [smas_pkg::SUM_BITS-1:0]   psxin;
		logic signed [smas_pkg::SUM_BITS-1:0]   psyin;

		if (i == 0) begin : g_head
			assign xin   = in_data.x_coord;
			assign yin   = in_data.y_coord;
			assign psxin = '0;
			assign psyin = '0;
		end else begin : g_body
			assign xin   = x_st[i-1];
			assign yin   = y_st[i-1];
			assign psxin = ps_x[i-1];
			assign psyin = ps_y[i-1];
		end

		smas_cell u_cell (
			.clk     (clk),
			.idx     (smas_pkg::IDX_BITS'(i)),
			.ctrl    (ctrl),
			.x_in    (xin),
			.y_in    (yin),
			.psx_in  (psxin),
			.psy_in  (psyin),
			.x_out   (x_st[i]),
			.y_out   (y_st[i]),
			.psx_out (ps_x[i]),
			.psy_out (ps_y[i])
		);
	end

	smas_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.den    (smas_pkg::WEIGHT_BITS'({k, 1'b1})),
		.num_x  (ps_x[smas_pkg::DEPTH-1]),
		.num_y  (ps_y[smas_pkg::DEPTH-1]),
		.done   (div_done),
		.quot_x (quot_x),
		.quot_y (quot_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smas_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			smas_pkg::ST_IDLE: begin
				if (accept && (in_data.stroke_end || jn >= k_ext)) begin
					state_d = smas_pkg::ST_SUM;
				end
			end
			smas_pkg::ST_SUM: begin
				// The last cell's sum is complete once every cell has seen the new control.
				if (sum_cnt_q == smas_pkg::CNT_BITS'(smas_pkg::DEPTH)) begin
					div_start = 1'b1;
					state_d   = smas_pkg::ST_DIV;
				end
			end
			smas_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = smas_pkg::ST_PUT;
				end
			end
			smas_pkg::ST_PUT: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = more ? smas_pkg::ST_SUM : smas_pkg::ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q      <= smas_pkg::HALF_RESET;
			pts_q       <= '0;
			pen_q       <= 1'b0;
			j_q         <= '0;
			q_q         <= '0;
			end_q       <= 1'b0;
			sum_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				half_q <= cfg_data;
			end
			if (accept) begin
				if (pts_q == '0) begin
					pen_q <= in_data.pen_is_down;
				end
				j_q       <= jn;
				sum_cnt_q <= '0;
				if (in_data.stroke_end) begin
					// Flush from the oldest pending point down to the newest one.
					pts_q <= '0;
					end_q <= 1'b1;
					q_q   <= (jn < k_ext) ? smas_pkg::HALF_BITS'(jn) : k;
				end else begin
					pts_q <= pts_inc;
					end_q <= 1'b0;
					q_q   <= k;
				end
			end else if (state_q == smas_pkg::ST_SUM) begin
				sum_cnt_q <= sum_cnt_q + smas_pkg::CNT_BITS'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
				if (more) begin
					q_q       <= q_q - smas_pkg::HALF_BITS'(1);
					sum_cnt_q <= '0;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.smooth_x       <= quot_x;
			out_q.smooth_y       <= quot_y;
			out_q.last_of_stroke <= end_q && (q_q == '0);
			out_q.pen_down_out   <= pen_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign cfg_ready = 1'b1;

endmodule

// File: hdl/smas_checker.sv
`include "stroke_moving_average_smoother_core_macros.svh"

module smas_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input smas_pkg::point_in_t           in_data,
	input logic                          out_valid,
	input logic                          out_stall,
	input smas_pkg::point_out_t          out_data,
	input logic                          cfg_valid,
	input logic                          cfg_ready,
	input logic [smas_pkg::CFG_BITS-1:0] cfg_data
);

	// A stalled output word stays valid and unchanged.
	`SMAS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled output word changed")

	// A point that ends a stroke always has results to flush, so input closes.
	`SMAS_ASSERT_NEXT(a_end_busy, clk, arst_n, in_valid && !in_stall && in_data.stroke_end, in_stall, "input open after a stroke end")

	// A new result is only produced while the input side is closed.
	`SMAS_ASSERT_SAME(a_out_when_busy, clk, arst_n, $rose(out_valid), $past(in_stall), "result appeared while idle")

	// The configuration write data must be known when written.
	`SMAS_ASSERT_SAME(a_cfg_known, clk, arst_n, cfg_valid && cfg_ready, !$isunknown(cfg_data), "unknown half window written")

endmodule

bind stroke_moving_average_smoother_core smas_checker u_smas_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.cfg_data  (cfg_data)
);
